// ===== design/grid_ray_caster_macros.svh =====
// assertion macros shared by the grid ray caster modules
// needs a clock named aclk and an active-low reset named aresetn in scope
`ifndef GRID_RAY_CASTER_MACROS_SVH
`define GRID_RAY_CASTER_MACROS_SVH

// same-cycle implication
`define GRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/grc_pkg.sv =====
// shared types and constants of the grid ray caster
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package grc_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int CFG_W   = 7;
    localparam int POS_W   = 25;
    localparam int DIR_W   = 18;
    localparam int RNG_W   = 24;
    localparam int CELL_W  = 8;
    localparam int IDX_W   = 12;
    localparam int FRAC_W  = 16;
    localparam int CRD_W   = 12;   // signed cell coordinate during the walk
    localparam int ABS_W   = 18;   // magnitude of a direction component
    localparam int NUM_W   = 27;   // distance to next boundary, Q.16
    localparam int PROD_W  = 45;   // shared multiplier result, also divider dividend
    localparam int BND_W   = CRD_W + FRAC_W;

    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 88;

    // register indexes
    localparam logic CFG_MAP_WIDTH  = 1'b0;
    localparam logic CFG_MAP_HEIGHT = 1'b1;

    // request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_CAST  = 1'b1;

    typedef enum logic [2:0] {
        MOP_NONE  = 3'd0,
        MOP_XN    = 3'd1,
        MOP_YN    = 3'd2,
        MOP_RANGE = 3'd3,
        MOP_END   = 3'd4
    } mul_op_t;

    typedef struct packed {
        logic    load_cast;
        logic    write_cell;
        mul_op_t mul_op;
        logic    step;
        logic    addr;
        logic    div_start;
        logic    div_sel;
        logic    take_q1;
        logic    take_q2;
        logic    out_hit;
        logic    out_miss;
    } dp_cmd_t;

    typedef struct packed {
        logic dir_zero;
        logic out_range;
        logic wall_hit;
        logic div_done;
        logic out_free;
    } dp_sts_t;

    typedef enum logic [13:0] {
        ST_IDLE    = 14'b00000000000001,
        ST_CHKDIR  = 14'b00000000000010,
        ST_MULA    = 14'b00000000000100,
        ST_MULB    = 14'b00000000001000,
        ST_MULC    = 14'b00000000010000,
        ST_STEP    = 14'b00000000100000,
        ST_ADDR    = 14'b00000001000000,
        ST_READ    = 14'b00000010000000,
        ST_MULD    = 14'b00000100000000,
        ST_DVS1    = 14'b00001000000000,
        ST_DIV1    = 14'b00010000000000,
        ST_DVS2    = 14'b00100000000000,
        ST_DIV2    = 14'b01000000000000,
        ST_RES     = 14'b10000000000000
    } state_t;

endpackage

`default_nettype wire

// ===== design/grc_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on grc_pkg
`timescale 1ns / 1ps
`default_nettype none

module grc_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [grc_pkg::PROD_W-1:0] dividend,
    input  wire logic [grc_pkg::ABS_W-1:0]  divisor,
    output logic                            busy,
    output logic                            done,
    output logic [grc_pkg::PROD_W-1:0]      quotient,
    output logic                            rem_nz
);
    import grc_pkg::*;

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0] quo_reg;
    logic [ABS_W-1:0]  rem_reg, dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg, done_reg;
    logic [ABS_W:0]    rem_sh;
    logic              fits;

    // trial subtract of the shifted remainder
    always_comb begin
        rem_sh = {rem_reg, quo_reg[PROD_W-1]};
        fits   = rem_sh >= {1'b0, dvs_reg};
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(PROD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[PROD_W-2:0], fits};
            rem_reg <= fits ? ABS_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[ABS_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;
    assign rem_nz   = rem_reg != '0;

endmodule

`default_nettype wire

// ===== design/grc_dp.sv =====
// datapath: map store, ray walk registers, shared multiplier, divider, result register
// depends on grc_pkg, grc_div and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "grid_ray_caster_macros.svh"

module grc_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic                              cfg_addr,
    input  wire logic [grc_pkg::CFG_W-1:0]         cfg_wdata,
    input  wire logic [grc_pkg::IDX_W-1:0]         in_cell_index,
    input  wire logic [grc_pkg::CELL_W-1:0]        in_cell_value,
    input  wire logic signed [grc_pkg::POS_W-1:0]  in_start_x,
    input  wire logic signed [grc_pkg::POS_W-1:0]  in_start_y,
    input  wire logic signed [grc_pkg::DIR_W-1:0]  in_dir_x,
    input  wire logic signed [grc_pkg::DIR_W-1:0]  in_dir_y,
    input  wire logic [grc_pkg::RNG_W-1:0]         in_ray_range,
    input  wire grc_pkg::dp_cmd_t                  cmd,
    output grc_pkg::dp_sts_t                       sts,
    input  wire logic                              m_tready,
    output logic                                   m_tvalid,
    output logic                                   out_hit,
    output logic signed [grc_pkg::POS_W-1:0]       out_end_x,
    output logic signed [grc_pkg::POS_W-1:0]       out_end_y,
    output logic [grc_pkg::RNG_W-1:0]              out_hit_distance,
    output logic [grc_pkg::CELL_W-1:0]             out_wall_type,
    output logic                                   out_face_axis
);
    import grc_pkg::*;

    localparam logic [NUM_W-1:0] Q_ONE = NUM_W'(1) << FRAC_W;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [47:0] v);
        logic signed [47:0] hi, lo;
        hi = 48'sd16777215;
        lo = -48'sd16777216;
        if (v > hi)      sat_pos = POS_W'(hi);
        else if (v < lo) sat_pos = POS_W'(lo);
        else             sat_pos = POS_W'(v);
    endfunction

    // configuration
    logic [CFG_W-1:0] w_cfg_reg, h_cfg_reg;
    logic [CFG_W-1:0] w_eff, h_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_cfg_reg <= CFG_W'(MAX_WIDTH);
            h_cfg_reg <= CFG_W'(MAX_HEIGHT);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_MAP_WIDTH:  w_cfg_reg <= cfg_wdata;
                CFG_MAP_HEIGHT: h_cfg_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_eff = (w_cfg_reg > CFG_W'(MAX_WIDTH))  ? CFG_W'(MAX_WIDTH)  : w_cfg_reg;
    assign h_eff = (h_cfg_reg > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : h_cfg_reg;

    // ray registers
    logic signed [POS_W-1:0] sx_reg, sy_reg;
    logic signed [DIR_W-1:0] dx_reg, dy_reg;
    logic [ABS_W-1:0]        adx_reg, ady_reg;
    logic [RNG_W-1:0]        rng_reg;
    logic signed [CRD_W-1:0] cx_reg, cy_reg;
    logic [NUM_W-1:0]        nx_reg, ny_reg, num_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic                    take_x_reg, out_range_reg, face_reg, in_map_reg;
    logic signed [BND_W-1:0] bnd_reg;
    logic [CELL_W-1:0]       rd_data_reg;
    logic signed [POS_W-1:0] eo_reg;
    logic [RNG_W-1:0]        dist_reg;

    logic                    dx_pos, dy_pos, dx_nz, dy_nz;
    logic [NUM_W-1:0]        num_sel;
    logic [ABS_W-1:0]        den_sel, dother_abs;
    logic [NUM_W-1:0]        mul_a;
    logic [ABS_W-1:0]        mul_b;
    logic [PROD_W-1:0]       mul_out;

    assign dx_nz   = dx_reg != '0;
    assign dy_nz   = dy_reg != '0;
    assign dx_pos  = dx_nz && !dx_reg[DIR_W-1];
    assign dy_pos  = dy_nz && !dy_reg[DIR_W-1];
    assign num_sel = take_x_reg ? nx_reg : ny_reg;
    assign den_sel = take_x_reg ? adx_reg : ady_reg;
    assign dother_abs = take_x_reg ? ady_reg : adx_reg;

    // shared multiplier operand selection
    always_comb begin
        case (cmd.mul_op)
            MOP_XN:    begin mul_a = nx_reg;          mul_b = ady_reg;    end
            MOP_YN:    begin mul_a = ny_reg;          mul_b = adx_reg;    end
            MOP_RANGE: begin mul_a = NUM_W'(rng_reg); mul_b = den_sel;    end
            MOP_END:   begin mul_a = num_reg;         mul_b = dother_abs; end
            default:   begin mul_a = '0;              mul_b = '0;         end
        endcase
        mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // divider
    logic [PROD_W-1:0] div_dividend, div_q;
    logic              div_busy, div_done, div_rnz;

    assign div_dividend = cmd.div_sel ? PROD_W'({num_reg, {FRAC_W{1'b0}}}) : prod_reg;

    grc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (den_sel),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q),
        .rem_nz   (div_rnz)
    );

    // floor of the signed offset along the other axis, added to its start
    logic                     q_neg;
    logic signed [46:0]       q_floor;
    logic signed [47:0]       eo_sum;

    always_comb begin
        q_neg   = take_x_reg ? dy_reg[DIR_W-1] : dx_reg[DIR_W-1];
        q_floor = q_neg ? -($signed(47'(div_q)) + $signed(47'(div_rnz)))
                        : $signed(47'(div_q));
        eo_sum  = 48'(take_x_reg ? sy_reg : sx_reg) + 48'(q_floor);
    end

    // walk registers
    always_ff @(posedge aclk) begin
        if (cmd.load_cast) begin
            sx_reg  <= in_start_x;
            sy_reg  <= in_start_y;
            dx_reg  <= in_dir_x;
            dy_reg  <= in_dir_y;
            rng_reg <= in_ray_range;
            adx_reg <= in_dir_x[DIR_W-1] ? ABS_W'(-in_dir_x) : ABS_W'(in_dir_x);
            ady_reg <= in_dir_y[DIR_W-1] ? ABS_W'(-in_dir_y) : ABS_W'(in_dir_y);
            cx_reg  <= CRD_W'(in_start_x >>> FRAC_W);
            cy_reg  <= CRD_W'(in_start_y >>> FRAC_W);
            nx_reg  <= in_dir_x[DIR_W-1] ? NUM_W'(in_start_x[FRAC_W-1:0])
                                         : Q_ONE - NUM_W'(in_start_x[FRAC_W-1:0]);
            ny_reg  <= in_dir_y[DIR_W-1] ? NUM_W'(in_start_y[FRAC_W-1:0])
                                         : Q_ONE - NUM_W'(in_start_y[FRAC_W-1:0]);
        end
        case (cmd.mul_op)
            MOP_XN:    prod_reg <= mul_out;
            MOP_YN:    take_x_reg <= dx_nz && (!dy_nz || prod_reg <= mul_out);
            MOP_RANGE: out_range_reg <= PROD_W'({num_sel, {FRAC_W{1'b0}}}) > mul_out;
            MOP_END:   prod_reg <= mul_out;
            default: ;
        endcase
        // cross the chosen boundary
        if (cmd.step) begin
            num_reg  <= num_sel;
            face_reg <= !take_x_reg;
            if (take_x_reg) begin
                bnd_reg <= dx_pos ? {cx_reg + 1'b1, {FRAC_W{1'b0}}} : {cx_reg, {FRAC_W{1'b0}}};
                cx_reg  <= dx_pos ? cx_reg + 1'b1 : cx_reg - 1'b1;
                nx_reg  <= nx_reg + Q_ONE;
            end else begin
                bnd_reg <= dy_pos ? {cy_reg + 1'b1, {FRAC_W{1'b0}}} : {cy_reg, {FRAC_W{1'b0}}};
                cy_reg  <= dy_pos ? cy_reg + 1'b1 : cy_reg - 1'b1;
                ny_reg  <= ny_reg + Q_ONE;
            end
        end
        if (cmd.take_q1) eo_reg <= sat_pos(eo_sum);
        if (cmd.take_q2) dist_reg <= div_q[RNG_W-1:0];
    end

    // map store
    logic [CELL_W-1:0] mem [STORE_DEPTH];
    logic [ADDR_W-1:0] rd_addr;
    logic              in_map;

    assign rd_addr = ADDR_W'(cx_reg) + ADDR_W'(ADDR_W'(cy_reg) * ADDR_W'(w_eff));
    assign in_map  = !cx_reg[CRD_W-1] && !cy_reg[CRD_W-1]
                     && (cx_reg < $signed({1'b0, CRD_W'(w_eff)}))
                     && (cy_reg < $signed({1'b0, CRD_W'(h_eff)}));

    always_ff @(posedge aclk) begin
        if (cmd.write_cell) mem[ADDR_W'(in_cell_index)] <= in_cell_value;
    end

    always_ff @(posedge aclk) begin
        if (cmd.addr) begin
            rd_data_reg <= mem[rd_addr];
            in_map_reg  <= in_map;
        end
    end

    // result register
    logic                    m_valid_reg, hit_reg, face_o_reg;
    logic signed [POS_W-1:0] ex_reg, ey_reg;
    logic [RNG_W-1:0]        dist_o_reg;
    logic [CELL_W-1:0]       wall_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_hit || cmd.out_miss) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_hit) begin
            hit_reg    <= 1'b1;
            ex_reg     <= take_x_reg ? sat_pos(48'(bnd_reg)) : eo_reg;
            ey_reg     <= take_x_reg ? eo_reg : sat_pos(48'(bnd_reg));
            dist_o_reg <= dist_reg;
            wall_reg   <= rd_data_reg;
            face_o_reg <= face_reg;
        end else if (cmd.out_miss) begin
            hit_reg    <= 1'b0;
            ex_reg     <= '0;
            ey_reg     <= '0;
            dist_o_reg <= '0;
            wall_reg   <= '0;
            face_o_reg <= 1'b0;
        end
    end

    assign m_tvalid         = m_valid_reg;
    assign out_hit          = hit_reg;
    assign out_end_x        = ex_reg;
    assign out_end_y        = ey_reg;
    assign out_hit_distance = dist_o_reg;
    assign out_wall_type    = wall_reg;
    assign out_face_axis    = face_o_reg;

    // status
    assign sts.dir_zero  = !dx_nz && !dy_nz;
    assign sts.out_range = out_range_reg;
    assign sts.wall_hit  = in_map_reg && (rd_data_reg != '0);
    assign sts.div_done  = div_done;
    assign sts.out_free  = !m_valid_reg || m_tready;

    `GRC_ASSERT_NEXT(a_hit_has_wall, cmd.out_hit, m_valid_reg && hit_reg && wall_reg != '0, "hit without wall type")
    `GRC_ASSERT_NEXT(a_miss_clean, cmd.out_miss, m_valid_reg && !hit_reg && dist_o_reg == '0, "miss result not cleared")
    `GRC_ASSERT_NOW(a_div_idle, cmd.div_start, !div_busy, "divider restarted while busy")

endmodule

`default_nettype wire

// ===== design/grc_ctrl.sv =====
// controller state machine sequencing writes, the cell walk and the hit math
// depends on grc_pkg
`timescale 1ns / 1ps
`default_nettype none

module grc_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    input  wire logic             req_type,
    output logic                  s_tready,
    input  wire grc_pkg::dp_sts_t sts,
    output grc_pkg::dp_cmd_t      cmd
);
    import grc_pkg::*;

    state_t state_reg, state_next;
    logic   miss_reg, miss_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            miss_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            miss_reg  <= miss_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        miss_next  = miss_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // no request is taken while reset is held
                s_tready = aresetn;
                if (s_tvalid && s_tready) begin
                    if (req_type == REQ_WRITE) begin
                        cmd.write_cell = 1'b1;
                    end else begin
                        cmd.load_cast = 1'b1;
                        state_next    = ST_CHKDIR;
                    end
                end
            end
            ST_CHKDIR: begin
                if (sts.dir_zero) begin
                    miss_next  = 1'b1;
                    state_next = ST_RES;
                end else begin
                    state_next = ST_MULA;
                end
            end
            ST_MULA: begin
                cmd.mul_op = MOP_XN;
                state_next = ST_MULB;
            end
            ST_MULB: begin
                cmd.mul_op = MOP_YN;
                state_next = ST_MULC;
            end
            ST_MULC: begin
                cmd.mul_op = MOP_RANGE;
                state_next = ST_STEP;
            end
            ST_STEP: begin
                if (sts.out_range) begin
                    miss_next  = 1'b1;
                    state_next = ST_RES;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR: begin
                cmd.addr   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                state_next = sts.wall_hit ? ST_MULD : ST_MULA;
            end
            ST_MULD: begin
                cmd.mul_op = MOP_END;
                state_next = ST_DVS1;
            end
            ST_DVS1: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV1;
            end
            ST_DIV1: begin
                if (sts.div_done) begin
                    cmd.take_q1 = 1'b1;
                    state_next  = ST_DVS2;
                end
            end
            ST_DVS2: begin
                cmd.div_sel   = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = ST_DIV2;
            end
            ST_DIV2: begin
                cmd.div_sel = 1'b1;
                if (sts.div_done) begin
                    cmd.take_q2 = 1'b1;
                    miss_next   = 1'b0;
                    state_next  = ST_RES;
                end
            end
            ST_RES: begin
                if (sts.out_free) begin
                    cmd.out_hit  = !miss_reg;
                    cmd.out_miss = miss_reg;
                    miss_next    = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/grid_ray_caster.sv =====
// Grid ray caster. A write request (tuser 0) stores one byte of the wall map.
// A cast request (tuser 1) walks cell to cell from the start point and returns
// one result: a hit with end point, distance, wall type and face, or a miss with
// all fields zero. Each cell crossed takes three passes through the single shared
// 45-bit multiplier, a step, a map read and its check, and a hit adds two 45-step
// restoring divisions. One request is worked on at a time; the result register
// lets the next request be taken while a result waits.
// depends on grc_pkg, grc_ctrl and grc_dp
`timescale 1ns / 1ps
`default_nettype none

module grid_ray_caster (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic                              cfg_addr,
    input  wire logic [grc_pkg::CFG_W-1:0]         cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // cell_index, cell_value, start_x, start_y, dir_x, dir_y, ray_range, zero pad
    input  wire logic [grc_pkg::IN_DATA_W-1:0]     s_tdata,
    // req_type
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // end_x, end_y, hit_distance, wall_type, face_axis, zero pad
    output logic [grc_pkg::OUT_DATA_W-1:0]         m_tdata,
    // hit
    output logic                                   m_tuser
);
    import grc_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    logic signed [POS_W-1:0] end_x, end_y;
    logic [RNG_W-1:0]        hit_distance;
    logic [CELL_W-1:0]       wall_type;
    logic                    face_axis;

    grc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    grc_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .in_cell_index    (s_tdata[11:0]),
        .in_cell_value    (s_tdata[19:12]),
        .in_start_x       (s_tdata[44:20]),
        .in_start_y       (s_tdata[69:45]),
        .in_dir_x         (s_tdata[87:70]),
        .in_dir_y         (s_tdata[105:88]),
        .in_ray_range     (s_tdata[129:106]),
        .cmd              (cmd),
        .sts              (sts),
        .m_tready         (m_tready),
        .m_tvalid         (m_tvalid),
        .out_hit          (m_tuser),
        .out_end_x        (end_x),
        .out_end_y        (end_y),
        .out_hit_distance (hit_distance),
        .out_wall_type    (wall_type),
        .out_face_axis    (face_axis)
    );

    // pack the result
    assign m_tdata = {5'b0, face_axis, wall_type, hit_distance, end_y, end_x};

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench for grid_ray_caster: random map writes and ray casts
// checked against an in-bench ray walk predictor; depends on grc_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
    import grc_pkg::*;

    typedef struct {
        logic                    req_type;
        logic [IDX_W-1:0]        cell_index;
        logic [CELL_W-1:0]       cell_value;
        logic signed [POS_W-1:0] start_x;
        logic signed [POS_W-1:0] start_y;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic [RNG_W-1:0]        ray_range;
    } ray_req_t;

    typedef struct {
        logic              hit;
        logic [POS_W-1:0]  end_x;
        logic [POS_W-1:0]  end_y;
        logic [RNG_W-1:0]  hit_distance;
        logic [CELL_W-1:0] wall_type;
        logic              face_axis;
    } ray_res_t;

    // holds the map copy, predicts each cast and checks returned results
    class ray_scoreboard;
        logic [CELL_W-1:0] cells [STORE_DEPTH];
        int unsigned       map_w;
        int unsigned       map_h;
        ray_res_t          pending [$];
        int                errors;

        function new();
            map_w  = 64;
            map_h  = 64;
            errors = 0;
        endfunction

        function longint floor_div(longint a, longint b);
            longint q;
            q = a / b;
            if ((a % b) != 0 && a < 0) q--;
            return q;
        endfunction

        function longint clamp_pos(longint v);
            if (v > 16777215) return 16777215;
            if (v < -16777216) return -16777216;
            return v;
        endfunction

        function void set_dims(logic idx, int unsigned val);
            if (idx == CFG_MAP_WIDTH) map_w = val;
            else map_h = val;
        endfunction

        // accepted request: store a cell or predict the cast outcome
        function void note_request(ray_req_t r);
            longint sx, sy, dx, dy, adx, ady, cx, cy, w, h, rng;
            longint bx, by, nx, ny, num, den, ex, ey;
            logic   take_x;
            ray_res_t res;
            if (r.req_type == REQ_WRITE) begin
                cells[r.cell_index] = r.cell_value;
                return;
            end
            res = '{default: '0};
            sx = r.start_x;
            sy = r.start_y;
            dx = r.dir_x;
            dy = r.dir_y;
            rng = r.ray_range;
            if (dx == 0 && dy == 0) begin
                pending.push_back(res);
                return;
            end
            w = (map_w > MAX_WIDTH) ? MAX_WIDTH : map_w;
            h = (map_h > MAX_HEIGHT) ? MAX_HEIGHT : map_h;
            adx = dx < 0 ? -dx : dx;
            ady = dy < 0 ? -dy : dy;
            cx = floor_div(sx, 65536);
            cy = floor_div(sy, 65536);
            forever begin
                bx = 0; by = 0; nx = 0; ny = 0;
                if (dx != 0) begin
                    bx = dx > 0 ? (cx + 1) * 65536 : cx * 65536;
                    nx = dx > 0 ? bx - sx : sx - bx;
                end
                if (dy != 0) begin
                    by = dy > 0 ? (cy + 1) * 65536 : cy * 65536;
                    ny = dy > 0 ? by - sy : sy - by;
                end
                if (dx == 0) take_x = 1'b0;
                else if (dy == 0) take_x = 1'b1;
                else take_x = (nx * ady <= ny * adx);
                num = take_x ? nx : ny;
                den = take_x ? adx : ady;
                // past the range: miss
                if (num * 65536 > rng * den) break;
                if (take_x) cx += dx > 0 ? 1 : -1;
                else cy += dy > 0 ? 1 : -1;
                if (cx >= 0 && cy >= 0 && cx < w && cy < h &&
                    cells[cx + cy * w] != 0) begin
                    if (take_x) begin
                        ex = bx;
                        ey = sy + floor_div(dy * nx, adx);
                    end else begin
                        ey = by;
                        ex = sx + floor_div(dx * ny, ady);
                    end
                    res.hit          = 1'b1;
                    res.end_x        = POS_W'(clamp_pos(ex));
                    res.end_y        = POS_W'(clamp_pos(ey));
                    res.hit_distance = RNG_W'((num * 65536) / den);
                    res.wall_type    = cells[cx + cy * w];
                    res.face_axis    = !take_x;
                    break;
                end
            end
            pending.push_back(res);
        endfunction

        function void report(string what, ray_res_t e, ray_res_t a);
            errors++;
            if (errors <= 10) begin
                $display("%0t mismatch %s: expected hit=%0d ex=%h ey=%h d=%h w=%h f=%0d",
                         $realtime, what, e.hit, e.end_x, e.end_y, e.hit_distance,
                         e.wall_type, e.face_axis);
                $display("    got hit=%0d ex=%h ey=%h d=%h w=%h f=%0d",
                         a.hit, a.end_x, a.end_y, a.hit_distance, a.wall_type,
                         a.face_axis);
            end
        endfunction

        // returned result against the oldest prediction
        function void check_result(logic hit, logic [OUT_DATA_W-1:0] data);
            ray_res_t got, exp_res;
            got.hit          = hit;
            got.end_x        = data[24:0];
            got.end_y        = data[49:25];
            got.hit_distance = data[73:50];
            got.wall_type    = data[81:74];
            got.face_axis    = data[82];
            if (pending.size() == 0) begin
                exp_res = '{default: '0};
                report("unexpected result", exp_res, got);
                return;
            end
            exp_res = pending.pop_front();
            if (got.hit !== exp_res.hit) report("hit", exp_res, got);
            else if (got.end_x !== exp_res.end_x) report("end_x", exp_res, got);
            else if (got.end_y !== exp_res.end_y) report("end_y", exp_res, got);
            else if (got.hit_distance !== exp_res.hit_distance)
                report("hit_distance", exp_res, got);
            else if (got.wall_type !== exp_res.wall_type) report("wall_type", exp_res, got);
            else if (got.face_axis !== exp_res.face_axis) report("face_axis", exp_res, got);
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic                  cfg_addr = 1'b0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    ray_scoreboard sb = new();
    bit steady = 1'b0;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int stall_left = 0;

    grid_ray_caster u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // run limit
    initial begin
        #1_000_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: random stalls plus an occasional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request) begin
            hold_request = 1'b0;
            m_tready <= 1'b0;
            hold_left <= 3000;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 15)
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                           : $urandom_range(1, 3);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata);
    end

    function int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one request, note it once accepted
    task send_request(ray_req_t r, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.req_type;
        s_tdata  <= {6'b0, r.ray_range, r.dir_y, r.dir_x, r.start_y, r.start_x,
                     r.cell_value, r.cell_index};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(r);
    endtask

    task wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task write_dims(int unsigned w, int unsigned h);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_MAP_WIDTH;
        cfg_wdata <= CFG_W'(w);
        @(posedge aclk);
        sb.set_dims(CFG_MAP_WIDTH, w);
        cfg_addr  <= CFG_MAP_HEIGHT;
        cfg_wdata <= CFG_W'(h);
        @(posedge aclk);
        sb.set_dims(CFG_MAP_HEIGHT, h);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function ray_req_t map_write(int idx, int val);
        ray_req_t r;
        r = '{default: '0};
        r.req_type   = REQ_WRITE;
        r.cell_index = IDX_W'(idx);
        r.cell_value = CELL_W'(val);
        return r;
    endfunction

    function ray_req_t cast(longint sx, longint sy, longint dx, longint dy, longint rng);
        ray_req_t r;
        r = '{default: '0};
        r.req_type   = REQ_CAST;
        r.start_x    = POS_W'(sx);
        r.start_y    = POS_W'(sy);
        r.dir_x      = DIR_W'(dx);
        r.dir_y      = DIR_W'(dy);
        r.ray_range  = RNG_W'(rng);
        r.cell_index = IDX_W'($urandom);
        r.cell_value = CELL_W'($urandom);
        return r;
    endfunction

    // random request: mostly casts near the map, some writes, a few wild casts
    function ray_req_t random_request();
        int unsigned wx, hy, r;
        longint sx, sy, dx, dy;
        wx = (sb.map_w == 0) ? 4 : ((sb.map_w > 64) ? 64 : sb.map_w);
        hy = (sb.map_h == 0) ? 4 : ((sb.map_h > 64) ? 64 : sb.map_h);
        r = $urandom_range(0, 99);
        if (r < 25)
            return map_write($urandom_range(0, 4095),
                             ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : 0);
        if (r < 29)
            return cast($signed(25'($urandom)), $signed(25'($urandom)),
                        $signed(18'($urandom)), $signed(18'($urandom)), 24'($urandom));
        sx = longint'($urandom_range(0, (wx + 4) * 65536)) - 2 * 65536;
        sy = longint'($urandom_range(0, (hy + 4) * 65536)) - 2 * 65536;
        dx = $signed(18'($urandom));
        dy = $signed(18'($urandom));
        r = $urandom_range(0, 19);
        if (r == 0) dx = 0;
        else if (r == 1) dy = 0;
        else if (r == 2) begin dx = 0; dy = 0; end
        return cast(sx, sy, dx, dy, $urandom_range(0, 24 * 65536));
    endfunction

    // every phase keeps width times height (after saturation) within the filled cells
    int phase_w [8] = '{32, 1, 127, 0, 10, 37, 16, 32};
    int phase_h [8] = '{32, 1, 16, 5, 0, 27, 127, 32};

    initial begin
        int n;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill every cell that a 32 by 32 map can reach before any cast
        write_dims(32, 32);
        for (n = 0; n < 1024; n++)
            send_request(map_write(n, ($urandom_range(0, 4) == 0) ?
                                      $urandom_range(1, 255) : 0), pick_gap());

        // directed corner cases
        send_request(map_write(0, 255), 0);
        send_request(map_write(4095, 1), 0);
        send_request(map_write(130, 8'h5A), pick_gap());
        send_request(map_write(64 + 3, 7), 0);
        send_request(cast(32768, 32768, 0, 0, 24'hFFFFFF), 0);          // no direction
        send_request(cast(3 * 65536 + 5, 2 * 65536, 0, 65536, 64 * 65536), 0);
        send_request(cast(10 * 65536, 1 * 65536 + 7, -65536, 0, 64 * 65536), 0);
        send_request(cast(16777215, 16777215, -131072, -131072, 24'hFFFFFF), 0);
        send_request(cast(-16777216, -16777216, 131071, 131071, 24'hFFFFFF), 0);
        send_request(cast(32768, 32768, 65536, 65536, 0), pick_gap());  // zero range
        send_request(cast(32768, 32768, 65536, 65536, 10 * 65536), 0);  // corner ties
        send_request(cast(-3 * 65536, 40000, 100000, 3000, 30 * 65536), 0); // from outside
        send_request(cast(70 * 65536, 70 * 65536, -65536, -65536, 24'hFFFFFF), 0);
        send_request(cast(5 * 65536, 5 * 65536, 1, -1, 24'hFFFFFF), 0); // tiny direction
        send_request(cast(2 * 65536, 2 * 65536, 131071, -131072, 24'hFFFFFF), 0);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            write_dims(phase_w[p], phase_h[p]);
            steady = (p == 1) || (p == 6);
            for (n = 0; n < 90; n++)
                send_request(random_request(), pick_gap());
            // long receiver hold-off while the sender keeps offering
            if (p == 2 || p == 5) begin
                hold_request = 1'b1;
                for (n = 0; n < 15; n++)
                    send_request(random_request(), 0);
            end
            wait_drained();
        end

        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== grid_ray_caster.f =====
+incdir+design
design/grc_pkg.sv
design/grc_div.sv
design/grc_dp.sv
design/grc_ctrl.sv
design/grid_ray_caster.sv
sim/testbench.sv
